// File: rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants, types and helpers of the min-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int DEPTH       = 256;
    localparam int DATA_W      = 32;
    localparam int AW          = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int OUT_W       = 32;
    localparam int COUNT_OUT_W = 9;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic push;
        logic pop;
        logic reload;
    } cmd_t;

    // datapath occupancy, for checks
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] min_cnt;
    } sts_t;

    typedef struct packed {
        logic [OUT_W-1:0]       top_value;
        logic [OUT_W-1:0]       min_value;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   is_empty;
        logic                   push_rejected;
        logic                   pop_ignored;
    } res_t;

    // input word to stored width, sign-extending or truncating
    function automatic logic [DATA_W-1:0] to_data(input logic [OUT_W-1:0] x);
        logic signed [63:0] w;
        begin
            w = 64'(signed'(x));
            return w[DATA_W-1:0];
        end
    endfunction

    // stored width to output word
    function automatic logic [OUT_W-1:0] to_out(input logic [DATA_W-1:0] x);
        logic signed [63:0] w;
        begin
            w = 64'(signed'(x));
            return w[OUT_W-1:0];
        end
    endfunction

endpackage

// File: rtl/core/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer: accept a transaction, wait for the top refresh after a pop,
// then hold the result until it is taken.
// ----------------------------------------------------------------------------
module mts_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_op,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output mts_pkg::cmd_t cmd
);
    import mts_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.push   = (s_op == OP_PUSH);
                    cmd.pop    = (s_op == OP_POP);
                    state_next = (s_op == OP_POP) ? ST_READ : ST_OUT;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.reload = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/mts_datapath.sv
// ----------------------------------------------------------------------------
// mts_datapath
// Value and minimum stacks: two RAMs, their counts and cached top entries.
// ----------------------------------------------------------------------------
module mts_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mts_pkg::cmd_t               cmd,
    input  logic [mts_pkg::OUT_W-1:0]   push_value,
    output mts_pkg::res_t               res,
    output mts_pkg::sts_t               sts
);
    import mts_pkg::*;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  mcnt_reg, mcnt_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] min_reg, min_next;
    logic              rej_reg, rej_next;
    logic              ign_reg, ign_next;

    logic [DATA_W-1:0] v;
    logic              full, empty, new_min;
    logic              val_we, min_we;
    logic [CNT_W-1:0]  cnt_dec, mcnt_dec;
    logic [DATA_W-1:0] val_rdata, min_rdata;

    assign v       = to_data(push_value);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign new_min = (mcnt_reg == '0) || ($signed(v) <= $signed(min_reg));
    assign val_we  = cmd.push && !full;
    assign min_we  = val_we && new_min;
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign mcnt_dec = mcnt_reg - CNT_W'(1);

    always_comb begin
        cnt_next  = cnt_reg;
        mcnt_next = mcnt_reg;
        top_next  = top_reg;
        min_next  = min_reg;
        rej_next  = rej_reg;
        ign_next  = ign_reg;
        if (cmd.push || cmd.pop) begin
            rej_next = cmd.push && full;
            ign_next = cmd.pop && empty;
        end
        if (val_we) begin
            cnt_next = cnt_reg + CNT_W'(1);
            top_next = v;
        end
        if (min_we) begin
            mcnt_next = mcnt_reg + CNT_W'(1);
            min_next  = v;
        end
        if (cmd.pop && !empty) begin
            cnt_next = cnt_dec;
            // drop the minimum entry when the popped value is it
            if (mcnt_reg != '0 && min_reg == top_reg) begin
                mcnt_next = mcnt_dec;
            end
        end
        if (cmd.reload) begin
            top_next = val_rdata;
            min_next = min_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            mcnt_reg <= '0;
            rej_reg  <= 1'b0;
            ign_reg  <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            mcnt_reg <= mcnt_next;
            rej_reg  <= rej_next;
            ign_reg  <= ign_next;
        end
        top_reg <= top_next;
        min_reg <= min_next;
    end

    mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (v),
        .raddr (cnt_dec[AW-1:0]),
        .rdata (val_rdata)
    );

    mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_min_ram (
        .aclk  (aclk),
        .we    (min_we),
        .waddr (mcnt_reg[AW-1:0]),
        .wdata (v),
        .raddr (mcnt_dec[AW-1:0]),
        .rdata (min_rdata)
    );

    always_comb begin
        res.top_value     = empty ? '0 : to_out(top_reg);
        res.min_value     = (mcnt_reg == '0) ? '0 : to_out(min_reg);
        res.entry_count   = COUNT_OUT_W'(cnt_reg);
        res.is_empty      = empty;
        res.push_rejected = rej_reg;
        res.pop_ignored   = ign_reg;
    end

    assign sts.cnt     = cnt_reg;
    assign sts.min_cnt = mcnt_reg;

endmodule

// File: rtl/core/min_tracking_stack_top.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// Bounded stack of signed values that also reports its current minimum.
// ----------------------------------------------------------------------------
// Each input transaction is a push (tuser 0, value in tdata) or a pop
// (tuser 1). One result transaction follows each input: top value, minimum,
// entry count and the empty, push-rejected and pop-ignored flags. The block
// handles one transaction at a time: a push offers its result in the cycle
// after acceptance, a pop only after passing the read and load states,
// because after a pop the new top and minimum are fetched through the
// registered read ports of the two stack RAMs. The next input is taken in
// the cycle after the result is taken.
// Stack RAMs need no clearing pass; only entries below the counts are used.
module min_tracking_stack_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input: tdata = push_value[31:0]; tuser = op (0 push, 1 pop)
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    // result: tdata = top_value[31:0], min_value[63:32], entry_count[72:64],
    //         zero pad [79:73]
    //         tuser = is_empty[0], push_rejected[1], pop_ignored[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser
);
    import mts_pkg::*;

    cmd_t cmd;
    res_t res;
    sts_t sts;

    // sequence the transaction
    mts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_op    (s_axis_tuser[0]),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    // hold both stacks and the result fields
    mts_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .push_value (s_axis_tdata),
        .res        (res),
        .sts        (sts)
    );

    // pack the result, pad up to whole bytes
    assign m_axis_tdata = {7'd0, res.entry_count, res.min_value, res.top_value};
    assign m_axis_tuser = {res.pop_ignored, res.push_rejected, res.is_empty};

`ifndef ASSERT_OFF
    // never take an input while a result is still on offer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while result pending");

    // minimum stack never deeper than the value stack, value stack never past DEPTH
    a_min_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (sts.min_cnt <= sts.cnt) && (sts.cnt <= CNT_W'(DEPTH)))
        else $error("stack counts inconsistent");

    // a non-empty value stack always has a minimum entry
    a_min_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (sts.cnt != '0) |-> (sts.min_cnt != '0))
        else $error("minimum stack empty under live values");

    // a push always leaves the stack non-empty unless rejected
    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> (sts.cnt != '0))
        else $error("push left stack empty");
`endif

endmodule
